// ===== sv/crcv_pkg.sv =====
`timescale 1ns / 1ps
// Package: types, constants and the CRC byte step of the chunk CRC verifier.
package crcv_pkg;

    localparam int NUM_CHUNKS = 5;

    localparam int unsigned CHUNK_W = 3;
    localparam int unsigned CSIZE_W = 24;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CHUNK_W-1:0] LAST_CHUNK = CHUNK_W'(NUM_CHUNKS - 1);

    localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [WORD_W-1:0] CRC_ONES = 32'hFFFF_FFFF;

    // Input item kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_CRC  = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [7:0]          data_byte;
        logic [CSIZE_W-1:0]  expected_size;
        logic [WORD_W-1:0]   expected_crc;
        logic                chunk_missing;
    } t_item;

    typedef struct packed {
        logic [CHUNK_W-1:0] chunk_index;
        logic               chunk_ok;
        logic               set_done;
        logic               set_ok;
    } t_result;

    // One reflected CRC-32 byte step, eight bit steps unrolled.
    function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] acc,
                                                   input logic [7:0] data);
        logic [WORD_W-1:0] c;
        c = acc ^ {24'h0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== sv/crcv_ifs.sv =====
`timescale 1ns / 1ps
// Interfaces: input item, result and configuration write channels.
interface crcv_in_if;
    import crcv_pkg::*;
    logic                valid;
    logic                ready;
    logic                kind;
    logic [7:0]          data_byte;
    logic [CSIZE_W-1:0]  expected_size;
    logic [WORD_W-1:0]   expected_crc;
    logic                chunk_missing;

    modport source (output valid, kind, data_byte, expected_size, expected_crc,
                    chunk_missing, input ready);
    modport sink   (input valid, kind, data_byte, expected_size, expected_crc,
                    chunk_missing, output ready);
endinterface

interface crcv_out_if;
    import crcv_pkg::*;
    logic               valid;
    logic               ready;
    logic [CHUNK_W-1:0] chunk_index;
    logic               chunk_ok;
    logic               set_done;
    logic               set_ok;

    modport source (output valid, chunk_index, chunk_ok, set_done, set_ok, input ready);
    modport sink   (input valid, chunk_index, chunk_ok, set_done, set_ok, output ready);
endinterface

interface crcv_cfg_if;
    import crcv_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== sv/crcv_accum.sv =====
`timescale 1ns / 1ps
// CRC and byte count accumulators with the chunk and set checks.
module crcv_accum #(
    parameter int NUM_CHUNKS = crcv_pkg::NUM_CHUNKS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  crcv_pkg::t_item               i_item,
    input  logic [crcv_pkg::WORD_W-1:0]   i_total_size,
    input  logic [crcv_pkg::WORD_W-1:0]   i_total_crc,
    output logic                          o_res_load,
    output crcv_pkg::t_result             o_res
);
    import crcv_pkg::*;

    localparam logic [CHUNK_W-1:0] LAST_IDX = CHUNK_W'(NUM_CHUNKS - 1);

    logic [WORD_W-1:0]  r_chunk_crc, n_chunk_crc;
    logic [WORD_W-1:0]  r_total_crc, n_total_crc;
    logic [CSIZE_W-1:0] r_chunk_cnt, n_chunk_cnt;
    logic [WORD_W-1:0]  r_total_cnt, n_total_cnt;
    logic [CHUNK_W-1:0] r_chunk,     n_chunk;
    logic               r_failed,    n_failed;

    logic chunk_ok;
    logic last;
    logic totals_ok;

    assign chunk_ok  = !i_item.chunk_missing && (r_chunk_cnt == i_item.expected_size)
                       && ((r_chunk_crc ^ CRC_ONES) == i_item.expected_crc);
    assign last      = (r_chunk >= LAST_IDX);
    assign totals_ok = (r_total_cnt == i_total_size)
                       && ((r_total_crc ^ CRC_ONES) == i_total_crc);

    assign o_res_load        = i_accept && (i_item.kind == KIND_END);
    assign o_res.chunk_index = r_chunk;
    assign o_res.chunk_ok    = chunk_ok;
    assign o_res.set_done    = last;
    assign o_res.set_ok      = last && !r_failed && chunk_ok && totals_ok;

    always_comb begin
        n_chunk_crc = r_chunk_crc;
        n_total_crc = r_total_crc;
        n_chunk_cnt = r_chunk_cnt;
        n_total_cnt = r_total_cnt;
        n_chunk     = r_chunk;
        n_failed    = r_failed;
        if (i_accept) begin
            if (i_item.kind == KIND_DATA) begin
                n_chunk_crc = crc_byte(r_chunk_crc, i_item.data_byte);
                n_total_crc = crc_byte(r_total_crc, i_item.data_byte);
                if (r_chunk_cnt != '1) begin
                    n_chunk_cnt = r_chunk_cnt + 1'b1;
                end
                if (r_total_cnt != '1) begin
                    n_total_cnt = r_total_cnt + 1'b1;
                end
            end else if (last) begin
                n_chunk_crc = CRC_ONES;
                n_total_crc = CRC_ONES;
                n_chunk_cnt = '0;
                n_total_cnt = '0;
                n_chunk     = '0;
                n_failed    = 1'b0;
            end else begin
                n_chunk_crc = CRC_ONES;
                n_chunk_cnt = '0;
                n_chunk     = r_chunk + 1'b1;
                n_failed    = r_failed || !chunk_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_crc <= CRC_ONES;
            r_total_crc <= CRC_ONES;
            r_chunk_cnt <= '0;
            r_total_cnt <= '0;
            r_chunk     <= '0;
            r_failed    <= 1'b0;
        end else begin
            r_chunk_crc <= n_chunk_crc;
            r_total_crc <= n_total_crc;
            r_chunk_cnt <= n_chunk_cnt;
            r_total_cnt <= n_total_cnt;
            r_chunk     <= n_chunk;
            r_failed    <= n_failed;
        end
    end

    a_chunk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chunk <= LAST_IDX)
        else $error("chunk index past end of set");

    a_set_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_load && last) |=> (r_chunk == '0 && r_total_cnt == '0 && !r_failed
                                  && r_total_crc == CRC_ONES))
        else $error("state not cleared at set end");

    a_byte_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_item.kind == KIND_DATA) |=> (r_chunk_cnt != '0 && r_total_cnt != '0))
        else $error("data byte not counted");

    a_fail_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_load && !last && !chunk_ok) |=> r_failed)
        else $error("chunk failure not recorded");

endmodule

// ===== sv/crcv_out_reg.sv =====
`timescale 1ns / 1ps
// Result register driving the output channel.
module crcv_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  crcv_pkg::t_result i_res,
    output logic              o_can_load,
    crcv_out_if.source        o_out
);
    import crcv_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;

    // Free when empty or being emptied this cycle
    assign o_can_load = !r_valid || o_out.ready;

    always_comb begin
        n_valid = r_valid;
        if (o_out.ready) begin
            n_valid = 1'b0;
        end
        if (i_load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.chunk_index = r_res.chunk_index;
    assign o_out.chunk_ok    = r_res.chunk_ok;
    assign o_out.set_done    = r_res.set_done;
    assign o_out.set_ok      = r_res.set_ok;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_can_load)
        else $error("result overwritten before taken");

    a_set_ok_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (!r_res.set_ok || r_res.set_done))
        else $error("set_ok without set_done");

endmodule

// ===== sv/chunked_backup_crc_verifier_unit.sv =====
`timescale 1ns / 1ps
// Top level of the chunked backup CRC-32 verifier.
//
//  Channel  | Dir | Payload                                             | Accept
//  ---------+-----+-----------------------------------------------------+-----------------
//  i_in     | in  | kind, data_byte, expected_size, expected_crc,       | valid && ready
//           |     | chunk_missing                                       |
//  o_out    | out | chunk_index, chunk_ok, set_done, set_ok             | valid && ready
//  i_cfg    | in  | index (0 total_size, 1 total_crc), wdata            | valid (ready = 1)
//
//  One input transaction per cycle while input ready is high. Data bytes update both CRCs and counters in
//  the cycle they are taken; an end item loads the result register, which is
//  shown on o_out from the next cycle.
//  Input ready drops only while a result waits in the output register and the
//  sink stalls; no bytes are lost or held elsewhere.
//  i_rst_n is synchronous, active low: CRCs to all ones, counters, chunk index
//  and failure flag to zero, config registers to zero, output empty.
module chunked_backup_crc_verifier_unit #(
    parameter int NUM_CHUNKS = crcv_pkg::NUM_CHUNKS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    crcv_in_if.sink    i_in,
    crcv_out_if.source o_out,
    crcv_cfg_if.sink   i_cfg
);
    import crcv_pkg::*;

    logic [WORD_W-1:0] r_total_size;
    logic [WORD_W-1:0] r_total_crc;

    t_item   item;
    t_result res;
    logic    accept;
    logic    res_load;
    logic    can_load;

    // Config writes always taken; the user must make writes only while idle, which the block does not enforce
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_size <= '0;
            r_total_crc  <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_TOTAL_SIZE: r_total_size <= i_cfg.wdata;
                CFG_TOTAL_CRC:  r_total_crc  <= i_cfg.wdata;
                default: ;
            endcase
        end
    end

    // Data bytes produce no result, so they could pass a stall; keep one simple
    // rule for both kinds so ready never depends on the payload.
    assign i_in.ready = can_load;
    assign accept     = i_in.valid && i_in.ready;

    assign item.kind          = i_in.kind;
    assign item.data_byte     = i_in.data_byte;
    assign item.expected_size = i_in.expected_size;
    assign item.expected_crc  = i_in.expected_crc;
    assign item.chunk_missing = i_in.chunk_missing;

    crcv_accum #(
        .NUM_CHUNKS (NUM_CHUNKS)
    ) u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_item       (item),
        .i_total_size (r_total_size),
        .i_total_crc  (r_total_crc),
        .o_res_load   (res_load),
        .o_res        (res)
    );

    crcv_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (res_load),
        .i_res      (res),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input stalled with empty output register");

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.kind == KIND_END) |=> o_out.valid)
        else $error("end transaction gave no result");

    a_data_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.kind == KIND_DATA && o_out.ready) |=> !o_out.valid)
        else $error("data transaction gave a result");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top: byte stream stimulus, chunk CRC scoreboard and result checks for the verifier.
module tb_top;
    import crcv_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 2;
    // Result register shows an end item in the cycle after it is taken; a little margin on top.
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_ITEMS  = 1250;
    // Final stretch of the run where neither side idles.
    localparam int QUIET_TAIL    = 200;
    localparam int HOLD_CYCLES   = 60;

    // Ways of spoiling an end item
    typedef enum int {
        FAULT_NONE,
        FAULT_MISSING,
        FAULT_SIZE,
        FAULT_CRC,
        FAULT_WILD
    } t_fault;

    // How the total registers relate to the set that follows
    typedef enum int {
        REGS_MATCH,
        REGS_SIZE_OFF,
        REGS_CRC_OFF,
        REGS_ZERO,
        REGS_ONES,
        REGS_RANDOM
    } t_regs;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    crcv_in_if  byte_ch ();
    crcv_out_if res_ch ();
    crcv_cfg_if reg_ch ();

    chunked_backup_crc_verifier_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (res_ch),
        .i_cfg   (reg_ch)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Items waiting for the driver, items of the set being built, verdicts awaiting the DUT.
    t_item   stream_q[$];
    t_item   staged_q[$];
    t_result verdict_q[$];
    t_item   cur_item;

    int n_pushed   = 0;
    int n_taken    = 0;
    int n_mismatch = 0;
    int tx_gap     = 0;
    int rx_gap     = 0;
    bit idle_en    = 1'b1;
    bit rx_hold    = 1'b0;

    // Scoreboard copy of the verifier state and registers.
    logic [WORD_W-1:0]  m_chunk_crc;
    logic [WORD_W-1:0]  m_total_crc;
    logic [CSIZE_W-1:0] m_chunk_len;
    logic [WORD_W-1:0]  m_total_len;
    logic [CHUNK_W-1:0] m_chunk_idx;
    logic               m_failed;
    logic [WORD_W-1:0]  m_reg_size = '0;
    logic [WORD_W-1:0]  m_reg_crc  = '0;

    // Running sums of the set under construction, used to build correct end items and totals.
    logic [WORD_W-1:0]  g_chunk_crc = CRC_ONES;
    logic [WORD_W-1:0]  g_total_crc = CRC_ONES;
    logic [CSIZE_W-1:0] g_chunk_len = '0;
    logic [WORD_W-1:0]  g_total_len = '0;

    // Reflected CRC-32 update, data folded in one bit per shift.
    function automatic logic [WORD_W-1:0] crc32_feed(input logic [WORD_W-1:0] acc,
                                                     input logic [7:0] b);
        logic [WORD_W-1:0] c;
        c = acc;
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {WORD_W{c[0] ^ b[k]}});
        end
        return c;
    endfunction

    function automatic bit settled();
        return (n_taken == n_pushed) && (verdict_q.size() == 0);
    endfunction

    task automatic model_clear();
        m_chunk_crc = CRC_ONES;
        m_total_crc = CRC_ONES;
        m_chunk_len = '0;
        m_total_len = '0;
        m_chunk_idx = '0;
        m_failed    = 1'b0;
    endtask

    // Advance the scoreboard by one accepted item; end items queue one verdict.
    task automatic model_take(input t_item it);
        t_result r;
        logic    ok;
        logic    last;
        if (it.kind == KIND_DATA) begin
            m_chunk_crc = crc32_feed(m_chunk_crc, it.data_byte);
            m_total_crc = crc32_feed(m_total_crc, it.data_byte);
            // both counters stick at all ones
            if (m_chunk_len != '1) m_chunk_len = m_chunk_len + 1'b1;
            if (m_total_len != '1) m_total_len = m_total_len + 1'b1;
        end else begin
            ok = !it.chunk_missing && (m_chunk_len == it.expected_size) &&
                 ((m_chunk_crc ^ CRC_ONES) == it.expected_crc);
            if (!ok) m_failed = 1'b1;
            last          = (m_chunk_idx >= LAST_CHUNK);
            r.chunk_index = m_chunk_idx;
            r.chunk_ok    = ok;
            r.set_done    = last;
            r.set_ok      = last && !m_failed && (m_total_len == m_reg_size) &&
                            ((m_total_crc ^ CRC_ONES) == m_reg_crc);
            verdict_q.push_back(r);
            if (last) begin
                model_clear();
            end else begin
                m_chunk_idx = m_chunk_idx + 1'b1;
                m_chunk_crc = CRC_ONES;
                m_chunk_len = '0;
            end
        end
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            n_mismatch++;
        end
    endtask

    // Stimulus building --------------------------------------------------------------

    // Data byte; end-item fields carry junk, which the DUT must ignore.
    task automatic add_byte(input logic [7:0] b);
        t_item it;
        it.kind          = KIND_DATA;
        it.data_byte     = b;
        it.expected_size = CSIZE_W'($urandom);
        it.expected_crc  = $urandom;
        it.chunk_missing = 1'($urandom_range(1));
        staged_q.push_back(it);
        g_chunk_crc = crc32_feed(g_chunk_crc, b);
        g_total_crc = crc32_feed(g_total_crc, b);
        g_chunk_len = g_chunk_len + 1'b1;
        g_total_len = g_total_len + 1'b1;
    endtask

    task automatic add_end_raw(input logic [CSIZE_W-1:0] size, input logic [WORD_W-1:0] crc,
                               input logic missing);
        t_item it;
        it.kind          = KIND_END;
        it.data_byte     = 8'($urandom);
        it.expected_size = size;
        it.expected_crc  = crc;
        it.chunk_missing = missing;
        staged_q.push_back(it);
        g_chunk_crc = CRC_ONES;
        g_chunk_len = '0;
    endtask

    task automatic add_end(input t_fault fault);
        logic [CSIZE_W-1:0] size;
        logic [WORD_W-1:0]  crc;
        logic               missing;
        size    = g_chunk_len;
        crc     = g_chunk_crc ^ CRC_ONES;
        missing = 1'b0;
        case (fault)
            FAULT_MISSING: missing = 1'b1;
            FAULT_SIZE:    size = size ^ (CSIZE_W'(1) << $urandom_range(CSIZE_W - 1));
            FAULT_CRC:     crc = crc ^ (WORD_W'(1) << $urandom_range(WORD_W - 1));
            FAULT_WILD: begin
                size    = CSIZE_W'($urandom);
                crc     = $urandom;
                missing = 1'($urandom_range(1));
            end
            default: ;
        endcase
        add_end_raw(size, crc, missing);
    endtask

    task automatic add_chunk(input int len, input t_fault fault);
        repeat (len) add_byte(8'($urandom));
        add_end(fault);
    endtask

    // Wait until every item is taken and every verdict seen, then let the pipe drain.
    task automatic wait_settled();
        do @(posedge i_clk); while (!settled());
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Called on a clock edge; returns after the write, with valid low again.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        reg_ch.valid <= 1'b1;
        reg_ch.index <= idx;
        reg_ch.wdata <= val;
        do @(posedge i_clk); while (!reg_ch.ready);
        if (idx == CFG_TOTAL_SIZE) m_reg_size = val;
        else                       m_reg_crc  = val;
        reg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Program the totals for the staged set while the DUT is idle, then hand the set over.
    task automatic release_set(input t_regs mode, input bit idle);
        logic [WORD_W-1:0] size_val;
        logic [WORD_W-1:0] crc_val;
        size_val = g_total_len;
        crc_val  = g_total_crc ^ CRC_ONES;
        case (mode)
            REGS_SIZE_OFF: size_val = size_val ^ (WORD_W'(1) << $urandom_range(WORD_W - 1));
            REGS_CRC_OFF:  crc_val  = crc_val ^ (WORD_W'(1) << $urandom_range(WORD_W - 1));
            REGS_ZERO: begin
                size_val = '0;
                crc_val  = '0;
            end
            REGS_ONES: begin
                size_val = '1;
                crc_val  = '1;
            end
            REGS_RANDOM: begin
                size_val = $urandom;
                crc_val  = $urandom;
            end
            default: ;
        endcase
        wait_settled();
        if ($urandom_range(1)) begin
            write_reg(CFG_TOTAL_SIZE, size_val);
            write_reg(CFG_TOTAL_CRC, crc_val);
        end else begin
            write_reg(CFG_TOTAL_CRC, crc_val);
            write_reg(CFG_TOTAL_SIZE, size_val);
        end
        idle_en = idle;
        foreach (staged_q[k]) stream_q.push_back(staged_q[k]);
        n_pushed += staged_q.size();
        staged_q.delete();
        g_total_crc = CRC_ONES;
        g_total_len = '0;
    endtask

    // Mostly short chunks, now and then a long one; half the sets are clean.
    task automatic random_set(input bit idle);
        bit     clean;
        int     len;
        int     pick;
        t_fault fault;
        t_regs  mode;
        clean = 1'($urandom_range(1));
        for (int c = 0; c < NUM_CHUNKS; c++) begin
            pick = $urandom_range(99);
            if (pick < 70)      len = $urandom_range(8);
            else if (pick < 95) len = $urandom_range(9, 40);
            else                len = $urandom_range(41, 120);
            fault = FAULT_NONE;
            if (!clean && $urandom_range(9) < 3) fault = t_fault'($urandom_range(1, 4));
            add_chunk(len, fault);
        end
        if (clean) begin
            pick = $urandom_range(9);
            if (pick < 7)       mode = REGS_MATCH;
            else if (pick == 7) mode = REGS_SIZE_OFF;
            else if (pick == 8) mode = REGS_CRC_OFF;
            else                mode = t_regs'($urandom_range(3, 5));
        end else begin
            mode = t_regs'($urandom_range(5));
        end
        release_set(mode, idle);
    endtask

    // Driver: one transaction offered at a time, random gap bursts between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
            tx_gap        <= 0;
        end else begin
            if (byte_ch.valid && byte_ch.ready) begin
                model_take(cur_item);
                n_taken++;
            end
            if (!byte_ch.valid || byte_ch.ready) begin
                if (tx_gap > 0) begin
                    byte_ch.valid <= 1'b0;
                    tx_gap        <= tx_gap - 1;
                end else if (stream_q.size() == 0) begin
                    byte_ch.valid <= 1'b0;
                end else if (idle_en && $urandom_range(3) == 0) begin
                    byte_ch.valid <= 1'b0;
                    tx_gap        <= $urandom_range(2);
                end else begin
                    cur_item                = stream_q.pop_front();
                    byte_ch.kind           <= cur_item.kind;
                    byte_ch.data_byte      <= cur_item.data_byte;
                    byte_ch.expected_size  <= cur_item.expected_size;
                    byte_ch.expected_crc   <= cur_item.expected_crc;
                    byte_ch.chunk_missing  <= cur_item.chunk_missing;
                    byte_ch.valid          <= 1'b1;
                end
            end
        end
    end

    // Monitor: check each result transaction against the oldest verdict, drive ready.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            rx_gap       <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (verdict_q.size() == 0) begin
                    $display({"%0t: unexpected result, expected none, ",
                              "actual index %0d ok %0b done %0b set_ok %0b"},
                             $time, res_ch.chunk_index, res_ch.chunk_ok, res_ch.set_done,
                             res_ch.set_ok);
                    n_mismatch++;
                end else begin
                    want = verdict_q.pop_front();
                    check_field("chunk_index", want.chunk_index, res_ch.chunk_index);
                    check_field("chunk_ok", want.chunk_ok, res_ch.chunk_ok);
                    check_field("set_done", want.set_done, res_ch.set_done);
                    check_field("set_ok", want.set_ok, res_ch.set_ok);
                end
            end
            if (rx_hold) begin
                res_ch.ready <= 1'b0;
            end else if (rx_gap > 0) begin
                res_ch.ready <= 1'b0;
                rx_gap       <= rx_gap - 1;
            end else if (idle_en && $urandom_range(3) == 0) begin
                res_ch.ready <= 1'b0;
                rx_gap       <= $urandom_range(2);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Back-pressure: the sink holds off for a long stretch while a set is streaming,
    // so the result register fills and input ready has to drop.
    initial begin
        int threshold;
        for (int k = 0; k < 2; k++) begin
            threshold = 300 + 500 * k;
            do @(posedge i_clk); while (n_taken < threshold || n_pushed - n_taken < 30);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_hold <= 1'b0;
        end
    end

    // Main sequence: reset, directed sets, random sets, drain, verdict.
    initial begin
        int goal;
        byte_ch.valid         = 1'b0;
        byte_ch.kind          = KIND_DATA;
        byte_ch.data_byte     = '0;
        byte_ch.expected_size = '0;
        byte_ch.expected_crc  = '0;
        byte_ch.chunk_missing = 1'b0;
        res_ch.ready          = 1'b0;
        reg_ch.valid          = 1'b0;
        reg_ch.index          = CFG_TOTAL_SIZE;
        reg_ch.wdata          = '0;
        model_clear();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // All chunks empty: every chunk CRC is zero and the totals match zeroed registers.
        repeat (NUM_CHUNKS) add_chunk(0, FAULT_NONE);
        release_set(REGS_ZERO, 1'b0);

        // Byte extremes, a missing chunk whose fields still match, field extremes on an
        // empty chunk, a flipped CRC bit; registers at all ones.
        add_byte(8'h00);
        add_byte(8'hFF);
        add_end(FAULT_NONE);
        add_byte(8'h5A);
        add_end(FAULT_MISSING);
        add_end_raw('1, '1, 1'b0);
        add_byte(8'h80);
        add_end(FAULT_CRC);
        add_byte(8'h01);
        add_byte(8'h7F);
        add_end(FAULT_NONE);
        release_set(REGS_ONES, 1'b1);

        // Clean set straight after a failed one: the sticky flag must have cleared.
        repeat (NUM_CHUNKS) add_chunk(1, FAULT_NONE);
        release_set(REGS_MATCH, 1'b1);

        goal = n_pushed + RANDOM_ITEMS;
        while (n_pushed < goal) begin
            random_set((n_pushed < goal - QUIET_TAIL) ? ($urandom_range(3) != 0) : 1'b0);
        end

        wait_settled();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_mismatch == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
